>>> rtl/mch_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Magnetometer heading package
// Shared widths, codes, CORDIC angle table and controller/datapath structs.
// ----------------------------------------------------------------------------
package mch_pkg;

  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 24;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int AXIS_W      = 2;
  localparam int NUM_AXES    = 3;

  localparam logic [KIND_W-1:0] KIND_SAMPLE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START_CAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_DURATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA = 2'd2;

  localparam logic [15:0] RESET_MIN_INTERVAL = 16'd100;
  localparam logic [15:0] RESET_CAL_DURATION = 16'd10000;
  localparam logic [15:0] RESET_FILTER_ALPHA = 16'd6554;

  // CORDIC widths: calibrated product, vector, angle (1/32768 degree)
  localparam int PROD_W     = 34;
  localparam int XW         = 45;
  localparam int ZW         = 26;
  localparam int ATAN_IDX_W = 5;

  localparam logic signed [ZW-1:0] FULL_TURN = 26'sd11796480;
  localparam logic signed [ZW-1:0] HALF_TURN = 26'sd5898240;
  localparam logic [17:0]          HEADING_WRAP = 18'd46080;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 26'sd1474560;
      5'd1:    v = 26'sd870484;
      5'd2:    v = 26'sd459940;
      5'd3:    v = 26'sd233473;
      5'd4:    v = 26'sd117189;
      5'd5:    v = 26'sd58652;
      5'd6:    v = 26'sd29333;
      5'd7:    v = 26'sd14667;
      5'd8:    v = 26'sd7334;
      5'd9:    v = 26'sd3667;
      5'd10:   v = 26'sd1833;
      5'd11:   v = 26'sd917;
      5'd12:   v = 26'sd458;
      5'd13:   v = 26'sd229;
      5'd14:   v = 26'sd115;
      5'd15:   v = 26'sd57;
      5'd16:   v = 26'sd29;
      5'd17:   v = 26'sd14;
      5'd18:   v = 26'sd7;
      5'd19:   v = 26'sd4;
      5'd20:   v = 26'sd2;
      5'd21:   v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic load;
    logic decode;
    logic mul;
    logic cinit;
    logic cstep;
    logic wrap;
    logic fmul;
    logic fsum;
    logic fin;
    logic dload;
    logic dstep;
    logic dstore;
    logic out_load;
  } mch_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              pass;
    logic              finish;
  } mch_sts_t;

endpackage
`default_nettype wire

>>> rtl/mch_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Magnetometer heading controller
// Sequences one request through decode, CORDIC, filter and scale division.
// ----------------------------------------------------------------------------
module mch_ctrl import mch_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int DIV_BITS     = 29,
  parameter int CNT_W        = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               m_tready,
  output logic               m_tvalid,
  output mch_cmd_t           cmd,
  output logic [CNT_W-1:0]   step,
  output logic [AXIS_W-1:0]  axis,
  input  mch_sts_t           sts
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_MUL    = 4'd2;
  localparam logic [3:0] ST_CINIT  = 4'd3;
  localparam logic [3:0] ST_CSTEP  = 4'd4;
  localparam logic [3:0] ST_WRAP   = 4'd5;
  localparam logic [3:0] ST_FMUL   = 4'd6;
  localparam logic [3:0] ST_FSUM   = 4'd7;
  localparam logic [3:0] ST_FIN    = 4'd8;
  localparam logic [3:0] ST_DLOAD  = 4'd9;
  localparam logic [3:0] ST_DSTEP  = 4'd10;
  localparam logic [3:0] ST_DSTORE = 4'd11;
  localparam logic [3:0] ST_OUT    = 4'd12;

  logic [3:0]        state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [AXIS_W-1:0] axis_cnt, axis_cnt_next;

  assign step = cnt;
  assign axis = axis_cnt;

  always_comb begin
    cmd           = '0;
    s_tready      = 1'b0;
    state_next    = state;
    cnt_next      = cnt;
    axis_cnt_next = axis_cnt;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.kind == KIND_SAMPLE && sts.pass) state_next = ST_MUL;
        else                                     state_next = ST_OUT;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_CINIT;
      end
      ST_CINIT: begin
        cmd.cinit  = 1'b1;
        cnt_next   = '0;
        state_next = ST_CSTEP;
      end
      ST_CSTEP: begin
        cmd.cstep = 1'b1;
        if (cnt == CNT_W'(CORDIC_STEPS - 1)) state_next = ST_WRAP;
        else                                 cnt_next   = cnt + 1'b1;
      end
      ST_WRAP: begin
        cmd.wrap   = 1'b1;
        state_next = ST_FMUL;
      end
      ST_FMUL: begin
        cmd.fmul   = 1'b1;
        state_next = ST_FSUM;
      end
      ST_FSUM: begin
        cmd.fsum = 1'b1;
        if (sts.finish) state_next = ST_FIN;
        else            state_next = ST_OUT;
      end
      ST_FIN: begin
        cmd.fin       = 1'b1;
        axis_cnt_next = '0;
        state_next    = ST_DLOAD;
      end
      ST_DLOAD: begin
        cmd.dload  = 1'b1;
        cnt_next   = '0;
        state_next = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd.dstep = 1'b1;
        if (cnt == CNT_W'(DIV_BITS - 1)) state_next = ST_DSTORE;
        else                             cnt_next   = cnt + 1'b1;
      end
      ST_DSTORE: begin
        cmd.dstore = 1'b1;
        if (axis_cnt == AXIS_W'(NUM_AXES - 1)) begin
          state_next = ST_OUT;
        end else begin
          axis_cnt_next = axis_cnt + 1'b1;
          state_next    = ST_DLOAD;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      axis_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      axis_cnt <= axis_cnt_next;
      if (cmd.out_load)  m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/mch_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Magnetometer heading datapath
// Calibration state, scaling multipliers, CORDIC, filter and scale divider.
// ----------------------------------------------------------------------------
module mch_dp import mch_pkg::*; #(
  parameter int SCALE_FRACTION_BITS = 12,
  parameter int CNT_W               = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  logic [KIND_W-1:0]      in_kind,
  input  mch_cmd_t               cmd,
  input  logic [CNT_W-1:0]       step,
  input  logic [AXIS_W-1:0]      axis,
  output mch_sts_t               sts,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int          DIV_BITS  = 16 + SCALE_FRACTION_BITS + 1;
  localparam logic [15:0] SCALE_ONE = 16'(1 << SCALE_FRACTION_BITS);

  // configuration
  logic [15:0] min_interval, cal_duration, filter_alpha;

  // calibration and filter state
  logic signed [15:0] last_raw [NUM_AXES];
  logic signed [15:0] axis_min [NUM_AXES];
  logic signed [15:0] axis_max [NUM_AXES];
  logic signed [15:0] axis_off [NUM_AXES];
  logic        [15:0] axis_scale [NUM_AXES];
  logic [15:0] filtered;
  logic [31:0] last_accept, cal_start;
  logic        active;

  // latched request
  logic [KIND_W-1:0]  kind_r;
  logic [31:0]        time_r;
  logic signed [15:0] raw_r [NUM_AXES];
  logic [AXIS_W-1:0]  lax_r;
  logic signed [15:0] loff_r;
  logic [15:0]        lscale_r;

  // working registers
  logic signed [PROD_W-1:0] cx, cy;
  logic                     zero_r;
  logic signed [XW-1:0]     x, y;
  logic signed [ZW-1:0]     z;
  logic [15:0]              h_r;
  logic [32:0]              p_old;
  logic [31:0]              p_new;
  logic                     acc_r, done_r;
  logic [DIV_BITS-1:0]      n_r;
  logic [15:0]              rem_r;

  // combinational
  logic               pass, finish;
  logic signed [16:0] diff_x, diff_y;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [XW-1:0] x0, y0, dxv, dyv;
  logic signed [ZW-1:0] z_pos, z_rnd, atan_v;
  logic [16:0]          h_raw;
  logic [15:0]          h_fix;
  logic [33:0]          fsum;
  logic [17:0]          fq;
  logic [15:0]          span [NUM_AXES];
  logic [15:0]          widest, span_sel;
  logic [16:0]          rs;
  logic                 rs_ge;

  assign pass   = (time_r - last_accept) >= {16'd0, min_interval};
  assign finish = active && ((time_r - cal_start) > {16'd0, cal_duration});
  assign sts.kind   = kind_r;
  assign sts.pass   = pass;
  assign sts.finish = finish;

  assign diff_x = {raw_r[0][15], raw_r[0]} - {axis_off[0][15], axis_off[0]};
  assign diff_y = {raw_r[1][15], raw_r[1]} - {axis_off[1][15], axis_off[1]};
  assign prod_x = PROD_W'(diff_x * $signed({1'b0, axis_scale[0]}));
  assign prod_y = PROD_W'(diff_y * $signed({1'b0, axis_scale[1]}));

  assign x0     = {{(XW-PROD_W-8){cx[PROD_W-1]}}, cx, 8'd0};
  assign y0     = {{(XW-PROD_W-8){cy[PROD_W-1]}}, cy, 8'd0};
  assign dxv    = y >>> step;
  assign dyv    = x >>> step;
  assign atan_v = atan_entry(ATAN_IDX_W'(step));

  // fold into one turn, round half up to 1/128 degree
  assign z_pos = z[ZW-1] ? z + FULL_TURN : z;
  assign z_rnd = z_pos + ZW'(128);
  assign h_raw = z_rnd[ZW-2:8];
  assign h_fix = ({1'b0, h_raw} >= HEADING_WRAP) ? 16'({1'b0, h_raw} - HEADING_WRAP)
                                                 : h_raw[15:0];

  assign fsum = {1'b0, p_old} + {2'b0, p_new} + 34'd32768;
  assign fq   = fsum[33:16];

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      span[k] = 16'({axis_max[k][15], axis_max[k]} - {axis_min[k][15], axis_min[k]});
    end
    widest = span[0];
    if (span[1] > widest) widest = span[1];
    if (span[2] > widest) widest = span[2];
  end

  assign span_sel = span[axis];
  assign rs       = {rem_r, n_r[DIV_BITS-1]};
  assign rs_ge    = rs >= {1'b0, span_sel};

  // state with a defined reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= RESET_MIN_INTERVAL;
      cal_duration <= RESET_CAL_DURATION;
      filter_alpha <= RESET_FILTER_ALPHA;
      for (int k = 0; k < NUM_AXES; k++) begin
        last_raw[k]   <= '0;
        axis_min[k]   <= '0;
        axis_max[k]   <= '0;
        axis_off[k]   <= '0;
        axis_scale[k] <= SCALE_ONE;
      end
      filtered    <= '0;
      last_accept <= '0;
      cal_start   <= '0;
      active      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_INTERVAL: min_interval <= cfg_data;
          CFG_CAL_DURATION: cal_duration <= cfg_data;
          CFG_FILTER_ALPHA: filter_alpha <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.decode) begin
        case (kind_r)
          KIND_SAMPLE: begin
            if (pass) begin
              last_accept <= time_r;
              for (int k = 0; k < NUM_AXES; k++) begin
                last_raw[k] <= raw_r[k];
                if (active && raw_r[k] < axis_min[k]) axis_min[k] <= raw_r[k];
                if (active && raw_r[k] > axis_max[k]) axis_max[k] <= raw_r[k];
              end
            end
          end
          KIND_START_CAL: begin
            active    <= 1'b1;
            cal_start <= time_r;
            for (int k = 0; k < NUM_AXES; k++) begin
              axis_min[k] <= last_raw[k];
              axis_max[k] <= last_raw[k];
            end
          end
          KIND_LOAD: begin
            if (lax_r < AXIS_W'(NUM_AXES)) begin
              axis_off[lax_r]   <= loff_r;
              axis_scale[lax_r] <= lscale_r;
            end
          end
          default: ;
        endcase
      end
      if (cmd.fsum) begin
        filtered <= (fq >= HEADING_WRAP) ? 16'(fq - HEADING_WRAP) : fq[15:0];
      end
      if (cmd.fin) begin
        active <= 1'b0;
        for (int k = 0; k < NUM_AXES; k++) begin
          axis_off[k] <= 16'(({axis_max[k][15], axis_max[k]}
                              + {axis_min[k][15], axis_min[k]}) >>> 1);
        end
      end
      if (cmd.dstore) begin
        if (widest == 16'd0)                    axis_scale[axis] <= SCALE_ONE;
        else if (span_sel == 16'd0)             axis_scale[axis] <= 16'hFFFF;
        else if (|n_r[DIV_BITS-1:16])           axis_scale[axis] <= 16'hFFFF;
        else                                    axis_scale[axis] <= n_r[15:0];
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      time_r   <= in_data[31:0];
      raw_r[0] <= in_data[47:32];
      raw_r[1] <= in_data[63:48];
      raw_r[2] <= in_data[79:64];
      lax_r    <= in_data[81:80];
      loff_r   <= in_data[97:82];
      lscale_r <= in_data[113:98];
    end
    if (cmd.decode) begin
      acc_r  <= (kind_r == KIND_SAMPLE) && pass;
      done_r <= 1'b0;
    end
    if (cmd.fin) done_r <= 1'b1;
    if (cmd.mul) begin
      cx     <= prod_x;
      cy     <= prod_y;
      zero_r <= (prod_x == '0) && (prod_y == '0);
    end
    if (cmd.cinit) begin
      if (x0 < 0) begin
        x <= -x0;
        y <= -y0;
        z <= HALF_TURN;
      end else begin
        x <= x0;
        y <= y0;
        z <= '0;
      end
    end
    if (cmd.cstep) begin
      if (y > 0) begin
        x <= x + dxv;
        y <= y - dyv;
        z <= z + atan_v;
      end else begin
        x <= x - dxv;
        y <= y + dyv;
        z <= z - atan_v;
      end
    end
    if (cmd.wrap) h_r <= zero_r ? 16'd0 : h_fix;
    if (cmd.fmul) begin
      p_old <= filtered * (17'h10000 - {1'b0, filter_alpha});
      p_new <= h_r * filter_alpha;
    end
    if (cmd.dload) begin
      n_r   <= {1'b0, widest, {SCALE_FRACTION_BITS{1'b0}}} + DIV_BITS'(span_sel >> 1);
      rem_r <= '0;
    end
    if (cmd.dstep) begin
      rem_r <= rs_ge ? 16'(rs - {1'b0, span_sel}) : rs[15:0];
      n_r   <= {n_r[DIV_BITS-2:0], rs_ge};
    end
    if (cmd.out_load) begin
      out_data <= {5'd0, done_r, active, acc_r, filtered};
    end
  end

endmodule
`default_nettype wire

>>> rtl/magnetometer_calibrated_heading.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Calibrated magnetometer compass heading
// Rate-limited hard/soft iron correction, CORDIC atan2 and heading filter.
// ----------------------------------------------------------------------------
// One request is handled at a time. A start-calibration, axis load or dropped
// sample goes from decode straight to the output register. An accepted sample
// runs through the scaling multipliers, the single shared CORDIC rotator that
// runs one micro-rotation per cycle, and the filter. A sample that closes the
// calibration window then runs the restoring divider, which yields one quotient
// bit per cycle for each axis in turn. The result waits in an output register;
// the next request is taken as soon as the block is idle, even while that
// result is still unread.
// Headings are in 1/128 degree (0 to 46079); min/max tracking uses raw counts.
// ----------------------------------------------------------------------------
module magnetometer_calibrated_heading import mch_pkg::*; #(
  parameter int CORDIC_STEPS        = 16,
  parameter int SCALE_FRACTION_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  // fields from bit 0: time_ms[31:0], mag_x[47:32], mag_y[63:48], mag_z[79:64],
  // axis_select[81:80], load_offset[97:82], load_scale[113:98], zero fill
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // fields from bit 0: kind[1:0]
  input  logic [KIND_W-1:0]      s_tuser,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // fields from bit 0: heading[15:0], sample_accepted[16], calibrating_now[17],
  // calibration_done[18], zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]            cfg_data
);

  localparam int DIV_BITS = 16 + SCALE_FRACTION_BITS + 1;
  localparam int STEP_MAX = (CORDIC_STEPS > DIV_BITS) ? CORDIC_STEPS : DIV_BITS;
  localparam int CNT_W    = $clog2(STEP_MAX);

  mch_cmd_t          cmd;
  mch_sts_t          sts;
  logic [CNT_W-1:0]  step;
  logic [AXIS_W-1:0] axis;

  // sequencing: one request through decode, rotate, filter and divide
  mch_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .DIV_BITS     (DIV_BITS),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd),
    .step     (step),
    .axis     (axis),
    .sts      (sts)
  );

  // arithmetic and calibration state
  mch_dp #(
    .SCALE_FRACTION_BITS (SCALE_FRACTION_BITS),
    .CNT_W               (CNT_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .in_kind   (s_tuser),
    .cmd       (cmd),
    .step      (step),
    .axis      (axis),
    .sts       (sts),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire

>>> rtl/mch_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Magnetometer heading port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module mch_checker import mch_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // hold an unread result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:0] < 16'd46080)
    else $error("heading out of range");

  a_done_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18] |-> m_tdata[16] && !m_tdata[17])
    else $error("calibration end without accepted sample");

endmodule

bind magnetometer_calibrated_heading mch_checker u_mch_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

>>> bench/heading_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heading checker
// Watches the request and result streams and the register port of the compass
// block. It keeps its own copy of the calibration state, works out the expected
// result of each request and compares every result with the oldest one waiting.
// ----------------------------------------------------------------------------
module heading_checker import mch_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [KIND_W-1:0]      s_tuser,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]            cfg_data,
  output int                     errors,
  output int                     pending
);

  localparam int STEPS = 16;
  localparam int FRAC  = 12;

  typedef struct packed {
    logic        done;
    logic        cal;
    logic        acc;
    logic [15:0] heading;
  } heading_result_t;

  heading_result_t expected_q[$];

  longint raw_last[3], ax_min[3], ax_max[3], ax_off[3], ax_scale[3];
  longint filt_hdg;
  logic [31:0] last_ms, cal_start;
  logic cal_on;
  logic [15:0] gap_ms, cal_len_ms, alpha;

  function automatic longint fshr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint angle_of(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_entry(i[4:0]);
      end else begin
        x -= dx; y += dy; z -= atan_entry(i[4:0]);
      end
    end
    while (z < 0) z += FULL_TURN;
    while (z >= FULL_TURN) z -= FULL_TURN;
    z = (z + 128) >>> 8;
    if (z >= HEADING_WRAP) z -= HEADING_WRAP;
    return z;
  endfunction

  task automatic close_calibration();
    longint span[3];
    longint widest, q;
    widest = 0;
    for (int k = 0; k < 3; k++) begin
      ax_off[k] = fshr(ax_max[k] + ax_min[k], 1);
      span[k] = ax_max[k] - ax_min[k];
      if (span[k] > widest) widest = span[k];
    end
    for (int k = 0; k < 3; k++) begin
      if (widest == 0) ax_scale[k] = 1 << FRAC;
      else if (span[k] == 0) ax_scale[k] = 65535;
      else begin
        q = ((widest << FRAC) + span[k] / 2) / span[k];
        ax_scale[k] = q > 65535 ? 65535 : q;
      end
    end
    cal_on = 1'b0;
  endtask

  task automatic predict_heading(logic [KIND_W-1:0] kind, logic [IN_TDATA_W-1:0] d);
    heading_result_t r;
    logic [31:0] now;
    longint raw[3];
    longint cx, cy, h;
    logic [1:0] ax;
    r = '0;
    now = d[31:0];
    if (kind == KIND_SAMPLE) begin
      if (32'(now - last_ms) >= gap_ms) begin
        r.acc = 1'b1;
        last_ms = now;
        raw[0] = $signed(d[47:32]);
        raw[1] = $signed(d[63:48]);
        raw[2] = $signed(d[79:64]);
        for (int k = 0; k < 3; k++) raw_last[k] = raw[k];
        cx = (raw[0] - ax_off[0]) * ax_scale[0];
        cy = (raw[1] - ax_off[1]) * ax_scale[1];
        h = angle_of(cx, cy);
        filt_hdg = (filt_hdg * (65536 - alpha) + h * alpha + 32768) >> 16;
        if (filt_hdg >= HEADING_WRAP) filt_hdg -= HEADING_WRAP;
        if (cal_on) begin
          for (int k = 0; k < 3; k++) begin
            if (raw[k] < ax_min[k]) ax_min[k] = raw[k];
            if (raw[k] > ax_max[k]) ax_max[k] = raw[k];
          end
          if (32'(now - cal_start) > cal_len_ms) begin
            close_calibration();
            r.done = 1'b1;
          end
        end
      end
    end else if (kind == KIND_START_CAL) begin
      cal_on = 1'b1;
      cal_start = now;
      for (int k = 0; k < 3; k++) begin
        ax_min[k] = raw_last[k];
        ax_max[k] = raw_last[k];
      end
    end else if (kind == KIND_LOAD) begin
      ax = d[81:80];
      if (ax < NUM_AXES) begin
        ax_off[ax] = $signed(d[97:82]);
        ax_scale[ax] = d[113:98];
      end
    end
    r.heading = filt_hdg[15:0];
    r.cal = cal_on;
    expected_q.push_back(r);
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    heading_result_t want;
    heading_result_t got;
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        raw_last[k] = 0; ax_min[k] = 0; ax_max[k] = 0; ax_off[k] = 0;
        ax_scale[k] = 1 << FRAC;
      end
      filt_hdg = 0; last_ms = '0; cal_start = '0; cal_on = 1'b0;
      gap_ms = RESET_MIN_INTERVAL; cal_len_ms = RESET_CAL_DURATION;
      alpha = RESET_FILTER_ALPHA;
      expected_q.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_INTERVAL: gap_ms = cfg_data;
          CFG_CAL_DURATION: cal_len_ms = cfg_data;
          CFG_FILTER_ALPHA: alpha = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[18:0];
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== got || m_tdata[OUT_TDATA_W-1:19] !== '0) begin
            $display({"%0t: mismatch expected hdg=%0d acc=%b cal=%b done=%b,",
                      " got hdg=%0d acc=%b cal=%b done=%b"},
                     $time, want.heading, want.acc, want.cal, want.done,
                     got.heading, got.acc, got.cal, got.done);
            errors <= errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready) predict_heading(s_tuser, s_tdata);
    end
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Compass heading testbench
// Drives timestamped samples, calibration starts and axis loads into the block
// over several register settings and idling phases; the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module testbench import mch_pkg::*;;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [KIND_W-1:0]      s_tuser = KIND_SAMPLE;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_MIN_INTERVAL;
  logic [15:0]            cfg_data = '0;
  int errors, pending;

  // Idle percentages for the sender and receiver in the current phase
  int send_idle = 0, recv_stall = 0;
  logic [31:0] clock_ms = '0;

  always #5 clk = ~clk;

  magnetometer_calibrated_heading u_dut (.*);
  heading_checker u_check (.*);

  // Receiver: stall at random, drawn fresh on each falling edge
  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall);

  // Send one request; hold it until the block takes it. Start at the falling edge
  // after tvalid dropped, or later if the sender idles; without idling the block is busy then.
  task automatic send_request(logic [KIND_W-1:0] kind, logic [IN_TDATA_W-1:0] d);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    s_tuser <= kind;
    s_tdata <= d;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  function automatic logic [IN_TDATA_W-1:0] pack_request(logic [31:0] t, logic [15:0] x,
      logic [15:0] y, logic [15:0] z, logic [1:0] ax, logic [15:0] off, logic [15:0] sc);
    return {6'd0, sc, off, ax, z, y, x, t};
  endfunction

  task automatic sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    send_request(KIND_SAMPLE, pack_request(clock_ms, x, y, z, 2'd0, 16'd0, 16'd0));
  endtask

  // Write a register once everything outstanding has drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random request: mostly samples at a pace around the interval, with
  // calibration runs, loads and requests of the unused kind mixed in
  task automatic random_request(int gap);
    int pick;
    logic [15:0] x, y, z;
    pick = $urandom_range(99);
    clock_ms += (pick < 10) ? $urandom_range(gap) : gap + $urandom_range(gap);
    if (pick < 3) clock_ms = $urandom;
    if ($urandom_range(3) == 0) begin
      x = $urandom; y = $urandom; z = $urandom;
    end else begin
      x = $urandom_range(2000) - 1000;
      y = $urandom_range(2000) - 1000;
      z = $urandom_range(2000) - 1000;
    end
    if (pick < 88) sample(x, y, z);
    else if (pick < 93)
      send_request(KIND_START_CAL, pack_request(clock_ms, x, y, z, 2'd0, 16'd0, 16'd0));
    else if (pick < 98)
      send_request(KIND_LOAD, pack_request(clock_ms, $urandom, $urandom, $urandom,
        $urandom_range(3), $urandom_range(1) ? $urandom : ($urandom_range(400) - 200),
        $urandom_range(1) ? $urandom : (16'd4096 + $urandom_range(2000) - 1000)));
    else
      send_request(2'd3, pack_request(clock_ms, x, y, z, $urandom, $urandom, $urandom));
  endtask

  initial begin
    int gaps[4] = '{100, 1, 65535, 7};
    int durs[4] = '{10000, 1, 65535, 900};
    int alph[4] = '{6554, 0, 65535, 40000};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: early sample dropped, extremes, quadrants, zero vector
    sample(16'h7fff, 16'h8000, 16'h0001);
    clock_ms = 100; sample(16'h0000, 16'h0000, 16'h0000);
    clock_ms += 100; sample(16'h7fff, 16'h7fff, 16'h7fff);
    clock_ms += 100; sample(16'h8000, 16'h8000, 16'h8000);
    clock_ms += 100; sample(16'h8000, 16'h0000, 16'h0000);
    clock_ms += 100; sample(16'h0000, 16'hffff, 16'h0000);
    clock_ms += 50;  sample(16'h0001, 16'h0001, 16'h0001);
    // Calibration with one narrow axis, then a run with every axis flat
    clock_ms += 100;
    send_request(KIND_START_CAL, pack_request(clock_ms, 0, 0, 0, 0, 0, 0));
    clock_ms += 5000; sample(16'd300, 16'hff00, 16'd5);
    clock_ms += 5000; sample(16'hff00, 16'd400, 16'd5);
    clock_ms += 5001; sample(16'd10, 16'd20, 16'd5);
    clock_ms += 100;
    send_request(KIND_START_CAL, pack_request(clock_ms, 0, 0, 0, 0, 0, 0));
    send_request(KIND_START_CAL, pack_request(clock_ms, 0, 0, 0, 0, 0, 0));
    clock_ms += 20000; sample(16'd10, 16'd20, 16'd5);
    // Loads on every axis, an ignored axis and an ignored kind
    send_request(KIND_LOAD, pack_request(clock_ms, 0, 0, 0, 2'd0, 16'h8000, 16'hffff));
    send_request(KIND_LOAD, pack_request(clock_ms, 0, 0, 0, 2'd1, 16'h7fff, 16'h0000));
    send_request(KIND_LOAD, pack_request(clock_ms, 0, 0, 0, 2'd2, 16'h0010, 16'h1000));
    send_request(KIND_LOAD, pack_request(clock_ms, 0, 0, 0, 2'd3, 16'h1234, 16'h5678));
    send_request(2'd3, pack_request(clock_ms, '1, '1, '1, '1, '1, '1));
    clock_ms += 100; sample(16'h1234, 16'h8765, 16'h0);
    // Timestamp wrap
    clock_ms = 32'hffff_ffc0; sample(16'd1, 16'd2, 16'd3);
    clock_ms = 32'h0000_0030; sample(16'd2, 16'd1, 16'd3);

    // Random phases over register settings and idling patterns
    for (int p = 0; p < 16; p++) begin
      write_reg(CFG_MIN_INTERVAL, gaps[p % 4]);
      write_reg(CFG_CAL_DURATION, durs[(p / 4) % 4]);
      write_reg(CFG_FILTER_ALPHA, alph[(p + p / 4) % 4]);
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 86; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 86; end
        default: begin send_idle = 11; recv_stall = 11; end
      endcase
      for (int i = 0; i < 83; i++)
        random_request(gaps[p % 4] > 5000 ? gaps[p % 4] : (durs[(p / 4) % 4] < 1000 ?
          gaps[p % 4] + 40 : gaps[p % 4] + 600));
    end

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
